// ===== design/sapa_pkg.sv =====
// shared types and constants of the subnet address pool allocator
package sapa_pkg;

   localparam int ADDR_W      = 32;
   localparam int WORD_W      = 32;
   localparam int BIT_W       = 5;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 11;
   localparam int PLEN_W      = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int HBITS_W     = 6;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SUBNET_PREFIX = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREFIX_LENGTH = 2'd1;

   localparam logic [PLEN_W-1:0]  PREFIX_LENGTH_RESET = 5'd24;
   localparam logic [ADDR_W-1:0]  SUBNET_PREFIX_RESET = 32'd0;
   localparam logic [COUNT_W-1:0] RESERVED_COUNT      = 11'd3;
   localparam logic [HBITS_W-1:0] MIN_HOST_BITS       = 6'd2;
   localparam logic [HBITS_W-1:0] ADDR_BITS           = 6'd32;

   typedef enum logic [2:0] {
      CLEAR,
      IDLE,
      SCAN,
      FREE_READ,
      FREE_CHECK,
      DONE
   } state_type;

endpackage

// ===== design/subnet_address_pool_allocator.sv =====
// subnet address pool allocator: used/free host map with next-free search
//
// requests come in on the req_ channel (valid/ready): req_command selects allocate or
// free, req_address carries the wanted or released address. every request gives one
// word on the rsp_ channel: status, granted address and the number of free hosts left.
// the used map lives in a one-write, one-read memory of 32-bit words, one word read per
// cycle with registered read data; the search unit looks at one word a cycle and picks
// its lowest free host.
// a free passes through the FREE_READ, FREE_CHECK and DONE states before rsp_valid. in the
// worst case an allocate scans every map word the pool spans (2^h / 32, at least 1):
// the scan reads the request's word, the words above it, wraps to zero and ends back at
// the request's word; it stops at the first word that holds a free host.
// req_ready is high only while the sequencer is idle; one request is in work at a time.
// a finished word waits in the rsp_ output register, so the next request may be taken
// while the receiver stalls; a second result then holds until that register empties.
// after reset, and after each csr_ write to a known register, a clearing pass writes
// every map word with only the network, server and broadcast hosts marked used;
// req_ready stays low during that pass.
module subnet_address_pool_allocator #(
   parameter int MAX_HOST_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [sapa_pkg::ADDR_W-1:0]          req_address,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sapa_pkg::STATUS_W-1:0]        rsp_status,
   output logic [sapa_pkg::ADDR_W-1:0]          rsp_granted_address,
   output logic [sapa_pkg::COUNT_W-1:0]         rsp_free_count,
   input  logic                                 csr_write_en,
   input  logic [sapa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sapa_pkg::ADDR_W-1:0]          csr_write_data
);
   import sapa_pkg::*;

   localparam int MAP_BITS  = 1 << MAX_HOST_BITS;
   localparam int MAP_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
   localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int HXW       = MAX_HOST_BITS + BIT_W;
   localparam logic [WORD_AW-1:0] LAST_MAP_WORD = WORD_AW'(MAP_WORDS - 1);

   // map memory
   logic [WORD_W-1:0]  mem [MAP_WORDS];
   logic [WORD_W-1:0]  rd_data_ff;
   logic               mem_we;
   logic [WORD_AW-1:0] mem_waddr;
   logic [WORD_AW-1:0] mem_raddr;
   logic [WORD_W-1:0]  mem_wdata;

   state_type state_ff, state_in;

   logic [WORD_AW-1:0]       clr_ff, clr_in;
   logic [ADDR_W-1:0]        prefix_ff, prefix_in;
   logic [PLEN_W-1:0]        plen_ff, plen_in;
   logic [COUNT_W-1:0]       used_ff, used_in;
   logic [MAX_HOST_BITS-1:0] host_ff, host_in;
   logic                     cmd_ff, cmd_in;
   logic                     foreign_ff, foreign_in;
   logic [WORD_AW-1:0]       iss_word_ff, iss_word_in;
   logic                     iss_first_ff, iss_first_in;
   logic                     iss_done_ff, iss_done_in;
   logic                     chk_valid_ff, chk_valid_in;
   logic [WORD_AW-1:0]       chk_word_ff, chk_word_in;
   logic                     chk_first_ff, chk_first_in;
   logic                     chk_last_ff, chk_last_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic [ADDR_W-1:0]        res_grant_ff, res_grant_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]        rsp_grant_ff, rsp_grant_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   // pool geometry
   logic [HBITS_W-1:0]       hb_raw;
   logic [HBITS_W-1:0]       pool_hbits;
   logic [ADDR_W-1:0]        hmask32;
   logic [MAX_HOST_BITS-1:0] hmask;
   logic [HXW-1:0]           hmask_x;
   logic [WORD_AW-1:0]       last_word;
   logic [COUNT_W-1:0]       size_lo;

   // request decode
   logic [MAX_HOST_BITS-1:0] req_host;
   logic [HXW-1:0]           req_hx;
   logic [HXW-1:0]           host_hx;
   logic [WORD_AW-1:0]       host_word;
   logic [BIT_W-1:0]         host_bit;

   // search unit
   logic [WORD_W-1:0]        chk_mask;
   logic [WORD_W-1:0]        free_bits;
   logic                     found;
   logic [BIT_W-1:0]         pick_bit;
   logic [MAX_HOST_BITS-1:0] pick_host;
   logic [WORD_W-1:0]        clr_word;

   // control
   logic cfg_hit;
   logic accept;
   logic issue;
   logic issue_last;
   logic alloc_hit;
   logic alloc_fail;
   logic reserved;
   logic free_ok;
   logic rsp_load;

   // pool size from prefix length, clamped to the supported range
   always_comb begin
      hb_raw = ADDR_BITS - {1'b0, plen_ff};
      if (hb_raw < MIN_HOST_BITS) begin
         pool_hbits = MIN_HOST_BITS;
      end else if (hb_raw > HBITS_W'(MAX_HOST_BITS)) begin
         pool_hbits = HBITS_W'(MAX_HOST_BITS);
      end else begin
         pool_hbits = hb_raw;
      end
      hmask32   = ~({ADDR_W{1'b1}} << pool_hbits);
      hmask     = hmask32[MAX_HOST_BITS-1:0];
      hmask_x   = HXW'(hmask);
      last_word = WORD_AW'(hmask_x[HXW-1:BIT_W]);
      size_lo   = COUNT_W'(hmask32[COUNT_W-1:0] + 1'b1);
   end

   always_comb begin
      req_host  = req_address[MAX_HOST_BITS-1:0] & hmask;
      req_hx    = HXW'(req_host);
      host_hx   = HXW'(host_ff);
      host_word = WORD_AW'(host_hx[HXW-1:BIT_W]);
      host_bit  = host_hx[BIT_W-1:0];
   end

   // one map word: which hosts are in the pool and free, lowest one wins
   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         chk_mask[b] = (HXW'({chk_word_ff, BIT_W'(b)}) <= hmask_x) &&
                       (!chk_first_ff || (BIT_W'(b) >= host_bit));
      end
      free_bits = ~rd_data_ff & chk_mask;
      found     = |free_bits;
      pick_bit  = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            pick_bit = BIT_W'(b);
         end
      end
      pick_host = MAX_HOST_BITS'({chk_word_ff, pick_bit});
   end

   // reserved hosts of the word being cleared
   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         clr_word[b] = (HXW'({clr_ff, BIT_W'(b)}) == '0) ||
                       (HXW'({clr_ff, BIT_W'(b)}) == hmask_x) ||
                       (HXW'({clr_ff, BIT_W'(b)}) == HXW'(hmask_x - 1'b1));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CLEAR: begin
            if (clr_ff == LAST_MAP_WORD) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (req_valid) begin
               state_in = (req_command == CMD_ALLOC) ? SCAN : FREE_READ;
            end
         end
         SCAN: begin
            if (chk_valid_ff && (found || chk_last_ff)) begin
               state_in = DONE;
            end
         end
         FREE_READ: begin
            state_in = FREE_CHECK;
         end
         FREE_CHECK: begin
            state_in = DONE;
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = CLEAR;
         end
      endcase
      if (cfg_hit) begin
         state_in = CLEAR;
      end
   end

   // control outputs of the sequencer
   always_comb begin
      cfg_hit    = csr_write_en &&
                   ((csr_index == CSR_SUBNET_PREFIX) || (csr_index == CSR_PREFIX_LENGTH));
      req_ready  = (state_ff == IDLE);
      accept     = req_ready && req_valid;
      issue      = (state_ff == SCAN) && !iss_done_ff;
      issue_last = !iss_first_ff && (iss_word_ff == host_word);
      alloc_hit  = (state_ff == SCAN) && chk_valid_ff && found;
      alloc_fail = (state_ff == SCAN) && chk_valid_ff && !found && chk_last_ff;
      reserved   = (host_ff == '0) || (host_ff == hmask) ||
                   (host_ff == MAX_HOST_BITS'(hmask - 1'b1));
      free_ok    = (state_ff == FREE_CHECK) && !foreign_ff && !reserved &&
                   rd_data_ff[host_bit];
      rsp_load   = (state_ff == DONE) && (!rsp_valid_ff || rsp_ready);

      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = clr_word;
      mem_raddr = (state_ff == SCAN) ? iss_word_ff : host_word;
      case (state_ff)
         CLEAR: begin
            mem_we = 1'b1;
         end
         SCAN: begin
            mem_we    = alloc_hit;
            mem_waddr = chk_word_ff;
            mem_wdata = rd_data_ff | (WORD_W'(1) << pick_bit);
         end
         FREE_CHECK: begin
            mem_we    = free_ok;
            mem_waddr = host_word;
            mem_wdata = rd_data_ff & ~(WORD_W'(1) << host_bit);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // register next values
   always_comb begin
      prefix_in = prefix_ff;
      plen_in   = plen_ff;
      if (csr_write_en && (csr_index == CSR_SUBNET_PREFIX)) begin
         prefix_in = csr_write_data;
      end
      if (csr_write_en && (csr_index == CSR_PREFIX_LENGTH)) begin
         plen_in = csr_write_data[PLEN_W-1:0];
      end

      clr_in = clr_ff;
      if (cfg_hit) begin
         clr_in = '0;
      end else if ((state_ff == CLEAR) && (clr_ff != LAST_MAP_WORD)) begin
         clr_in = WORD_AW'(clr_ff + 1'b1);
      end

      used_in = used_ff;
      if (cfg_hit) begin
         used_in = RESERVED_COUNT;
      end else if (alloc_hit) begin
         used_in = COUNT_W'(used_ff + 1'b1);
      end else if (free_ok) begin
         used_in = COUNT_W'(used_ff - 1'b1);
      end

      host_in    = host_ff;
      cmd_in     = cmd_ff;
      foreign_in = foreign_ff;
      if (accept) begin
         host_in    = req_host;
         cmd_in     = req_command;
         foreign_in = ((req_address ^ prefix_ff) & ~hmask32) != '0;
      end

      // scan pipeline: issue a word read, check the previous word's data
      iss_word_in  = iss_word_ff;
      iss_first_in = iss_first_ff;
      iss_done_in  = iss_done_ff;
      chk_valid_in = 1'b0;
      chk_word_in  = chk_word_ff;
      chk_first_in = chk_first_ff;
      chk_last_in  = chk_last_ff;
      if (accept) begin
         iss_word_in  = WORD_AW'(req_hx[HXW-1:BIT_W]);
         iss_first_in = 1'b1;
         iss_done_in  = 1'b0;
      end else if (issue) begin
         iss_word_in  = (iss_word_ff == last_word) ? '0 : WORD_AW'(iss_word_ff + 1'b1);
         iss_first_in = 1'b0;
         iss_done_in  = issue_last;
         chk_valid_in = 1'b1;
         chk_word_in  = iss_word_ff;
         chk_first_in = iss_first_ff;
         chk_last_in  = issue_last;
      end

      res_status_in = res_status_ff;
      res_grant_in  = res_grant_ff;
      if (alloc_hit) begin
         res_status_in = STATUS_OK;
         res_grant_in  = (prefix_ff & ~hmask32) | ADDR_W'(pick_host);
      end else if (alloc_fail) begin
         res_status_in = STATUS_FULL;
         res_grant_in  = '0;
      end else if (state_ff == FREE_CHECK) begin
         res_status_in = free_ok ? STATUS_OK : STATUS_INVALID;
         res_grant_in  = '0;
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_grant_in  = res_grant_ff;
         rsp_count_in  = COUNT_W'(size_lo - used_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         clr_ff       <= '0;
         prefix_ff    <= SUBNET_PREFIX_RESET;
         plen_ff      <= PREFIX_LENGTH_RESET;
         used_ff      <= RESERVED_COUNT;
         iss_done_ff  <= 1'b1;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         prefix_ff    <= prefix_in;
         plen_ff      <= plen_in;
         used_ff      <= used_in;
         iss_done_ff  <= iss_done_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      host_ff       <= host_in;
      cmd_ff        <= cmd_in;
      foreign_ff    <= foreign_in;
      iss_word_ff   <= iss_word_in;
      iss_first_ff  <= iss_first_in;
      chk_word_ff   <= chk_word_in;
      chk_first_ff  <= chk_first_in;
      chk_last_ff   <= chk_last_in;
      res_status_ff <= res_status_in;
      res_grant_ff  <= res_grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_grant_ff;
   assign rsp_free_count      = rsp_count_ff;

`ifndef NO_ASSERTIONS
   // a write to the prefix or prefix length register always restarts the clearing pass
   assert property (@(posedge clock) disable iff (reset) cfg_hit |=> state_ff == CLEAR)
      else $error("config write did not restart map clear");

   // failed requests never carry an address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_granted_address == '0)
      else $error("failed response carries an address");

   // the search never grants a host outside the pool
   assert property (@(posedge clock) disable iff (reset) alloc_hit |-> pick_host <= hmask)
      else $error("granted host outside the pool");

   // only allocate requests run the scan
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN) |-> cmd_ff == CMD_ALLOC)
      else $error("scan running for a free request");
`endif

endmodule
